// ----- hdl/ffca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared widths, codes and control structs of the first-fit chunk allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int CB_W        = 13;  // chunk size register
  localparam int NCFG_W      = 7;   // pool size register
  localparam int BYTES_W     = 19;
  localparam int OFF_W       = 18;
  localparam int STATUS_W    = 2;
  localparam int REM_W       = 19;
  localparam int DIV_W       = 20;  // rounded-up byte count needs one more bit
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CB_W-1:0]   CB_MIN     = 13'd1;
  localparam logic [CB_W-1:0]   CB_MAX     = 13'd4096;
  localparam logic [CB_W-1:0]   CB_RESET   = 13'd64;
  localparam logic [NCFG_W-1:0] NCFG_RESET = 7'd64;

  // configuration register indexes
  localparam logic REG_CHUNK_BYTES = 1'b0;
  localparam logic REG_CHUNKS      = 1'b1;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_NORUN   = 2'd2,
    STAT_OUTSIDE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MUL_POOL  = 2'd0,
    MUL_START = 2'd1,
    MUL_CNT   = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    logic     div_off;
    logic     need_we;
    logic     first_we;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     rd_init;
    logic     rd_run;
    logic     count_mode;
    logic     fill_alloc_init;
    logic     fill_free_init;
    logic     fill_step;
    logic     status_we;
    status_e  status;
    logic     start_we;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic div_done;
    logic need_zero;
    logic need_gt_n;
    logic outside;
    logic found;
    logic rd_done;
    logic fill_last;
  } sts_t;

endpackage

// ----- hdl/first_fit_chunk_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator
// First-fit contiguous allocator over a pool of equal chunks with a free bitmap.
// ----------------------------------------------------------------------------
// Each request word yields exactly one result word. Allocate (tuser = 0)
// rounds byte_count up to whole chunks, takes the lowest run of that many
// free chunks inside the pool and returns its byte offset; free (tuser = 1)
// releases the chunks from the one holding offset on, clipped at the pool
// end. Every result carries the free bytes left in the pool. After reset the
// block sweeps the bitmap to all-free before it takes the first request;
// config writes are taken at any time but must only be issued while the
// block is idle. One request at a time: the bitmap sits in a single-port-read
// memory walked one chunk per cycle, and chunk counts come from a bit-serial
// divider.
// A finished result waits in an output register, so the next request is
// taken while the previous result is still pending.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator #(
  parameter int MAX_CHUNKS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [ffca_pkg::CB_W-1:0]           cfg_data_i,
  // request stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [18:0] byte_count, [36:19] offset, [39:37] zero
  input  logic [ffca_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [0] kind
  input  logic                                s_axis_tuser_i,
  // result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [1:0] status, [19:2] start_offset, [38:20] remaining_bytes, [39] zero
  output logic [ffca_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  ffca_pkg::cmd_t cmd;
  ffca_pkg::sts_t sts;

  // config registers are plain flops, always ready
  assign cfg_ready_o = 1'b1;

  ffca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffca_datapath #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_kind_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// ----- hdl/ffca_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_div
// Restoring divider, one quotient bit per cycle, by a chunk-sized divisor.
// ----------------------------------------------------------------------------
module ffca_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ffca_pkg::DIV_W-1:0]   dividend_i,
  input  logic [ffca_pkg::CB_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [ffca_pkg::DIV_W-1:0]   quotient_o
);

  localparam int DW   = ffca_pkg::DIV_W;
  localparam int CBW  = ffca_pkg::CB_W;
  localparam int CNTW = $clog2(DW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [CBW-1:0]  rem_q, rem_d;
  logic [CBW-1:0]  dvs_q, dvs_d;
  logic [CBW:0]    partial;
  logic            fits;

  assign partial = {rem_q, quo_q[DW-1]};
  assign fits    = partial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], fits};
      rem_d = fits ? CBW'(partial - {1'b0, dvs_q}) : partial[CBW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNTW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hdl/ffca_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_datapath
// Config registers, free bitmap memory, scan/count reader, fill writer,
// shared multiplier, divider and result register.
// ----------------------------------------------------------------------------
module ffca_datapath #(
  parameter int MAX_CHUNKS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [ffca_pkg::CB_W-1:0]          cfg_data_i,
  input  logic                               in_kind_i,
  input  logic [ffca_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  ffca_pkg::cmd_t                     cmd_i,
  output ffca_pkg::sts_t                     sts_o,
  output logic [ffca_pkg::OUT_TDATA_W-1:0]   out_data_o
);

  localparam int IW  = $clog2(MAX_CHUNKS);
  localparam int CW  = $clog2(MAX_CHUNKS + 1);
  localparam int CBW = ffca_pkg::CB_W;
  localparam int QW  = ffca_pkg::DIV_W;
  localparam int PW  = CW + CBW;
  localparam int BW  = ffca_pkg::BYTES_W;
  localparam int OW  = ffca_pkg::OFF_W;
  localparam int RW  = ffca_pkg::REM_W;
  localparam int SW  = ffca_pkg::STATUS_W;

  // config
  logic [CBW-1:0]              cb_cfg_q;
  logic [ffca_pkg::NCFG_W-1:0] n_cfg_q;
  logic [CBW-1:0]              cb_eff;
  logic [CW-1:0]               n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_cfg_q <= ffca_pkg::CB_RESET;
      n_cfg_q  <= ffca_pkg::NCFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ffca_pkg::REG_CHUNK_BYTES: cb_cfg_q <= cfg_data_i;
        ffca_pkg::REG_CHUNKS:      n_cfg_q  <= cfg_data_i[ffca_pkg::NCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cb_cfg_q < ffca_pkg::CB_MIN)      cb_eff = ffca_pkg::CB_MIN;
    else if (cb_cfg_q > ffca_pkg::CB_MAX) cb_eff = ffca_pkg::CB_MAX;
    else                                  cb_eff = cb_cfg_q;
    if (n_cfg_q == '0)                             n_eff = CW'(1);
    else if (32'(n_cfg_q) > 32'(MAX_CHUNKS))       n_eff = CW'(MAX_CHUNKS);
    else                                           n_eff = CW'(n_cfg_q);
  end

  // request
  logic          kind_q;
  logic [BW-1:0] bytes_q;
  logic [OW-1:0] off_q;
  logic [QW-1:0] need_q;
  logic [QW-1:0] first_q;

  // divider
  logic [QW-1:0] div_dividend;
  logic          div_done;
  logic [QW-1:0] div_quo;

  assign div_dividend = cmd_i.div_off ? QW'(off_q)
                                      : QW'(bytes_q) + QW'(cb_eff) - QW'(1);

  ffca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cb_eff),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // bitmap memory, one bit per chunk, 1 = free
  logic          free_mem_q [MAX_CHUNKS];
  logic          rd_data_q;
  logic [CW-1:0] rd_addr_q;
  logic          rd_pend_q;
  logic [IW-1:0] rd_idx_q;
  logic [CW-1:0] run_q;
  logic [CW-1:0] cnt_q;
  logic          found_q;
  logic [IW-1:0] found_idx_q;
  logic          rd_issue;
  logic          rd_take;

  logic [IW-1:0] wr_idx_q;
  logic [CW-1:0] fill_hi_q;
  logic          fill_val_q;
  logic [QW:0]   free_end;
  logic [CW-1:0] free_last;

  assign rd_issue = cmd_i.rd_run && (rd_addr_q < n_eff) && !found_q;
  assign rd_take  = cmd_i.rd_run && rd_pend_q && !found_q;

  assign free_end  = {1'b0, first_q} + {1'b0, need_q};
  assign free_last = (free_end > (QW + 1)'(n_eff)) ? n_eff : free_end[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_step) free_mem_q[wr_idx_q] <= fill_val_q;
    if (rd_issue)        rd_data_q <= free_mem_q[rd_addr_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q   <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      run_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      // reset state sweeps the whole memory to free
      wr_idx_q    <= '0;
      fill_hi_q   <= CW'(MAX_CHUNKS);
      fill_val_q  <= 1'b1;
    end else begin
      if (cmd_i.rd_init) begin
        rd_addr_q <= '0;
        rd_pend_q <= 1'b0;
        run_q     <= '0;
        cnt_q     <= '0;
        found_q   <= 1'b0;
      end else if (cmd_i.rd_run) begin
        rd_pend_q <= rd_issue;
        if (rd_issue) begin
          rd_addr_q <= rd_addr_q + 1'b1;
          rd_idx_q  <= rd_addr_q[IW-1:0];
        end
        if (rd_take) begin
          if (cmd_i.count_mode) begin
            cnt_q <= cnt_q + CW'(rd_data_q);
          end else if (rd_data_q) begin
            run_q <= run_q + 1'b1;
            if (CW'(run_q + 1'b1) == need_q[CW-1:0]) begin
              found_q     <= 1'b1;
              found_idx_q <= rd_idx_q - need_q[IW-1:0] + IW'(1);
            end
          end else begin
            run_q <= '0;
          end
        end
      end

      if (cmd_i.fill_alloc_init) begin
        wr_idx_q   <= found_idx_q;
        fill_hi_q  <= CW'(found_idx_q) + need_q[CW-1:0];
        fill_val_q <= 1'b0;
      end else if (cmd_i.fill_free_init) begin
        wr_idx_q   <= first_q[IW-1:0];
        fill_hi_q  <= free_last;
        fill_val_q <= 1'b1;
      end else if (cmd_i.fill_step) begin
        wr_idx_q <= wr_idx_q + 1'b1;
      end
    end
  end

  // shared multiplier, pool size, chunk index or count times chunk size
  logic [CW-1:0]  mul_a;
  logic [PW-1:0]  prod_q;

  always_comb begin
    case (cmd_i.mul_sel)
      ffca_pkg::MUL_POOL:  mul_a = n_eff;
      ffca_pkg::MUL_START: mul_a = CW'(found_idx_q);
      ffca_pkg::MUL_CNT:   mul_a = cnt_q;
      default:             mul_a = n_eff;
    endcase
  end

  // work and result registers
  logic [SW-1:0] status_q;
  logic [OW-1:0] start_q;
  logic [SW-1:0] out_status_q;
  logic [OW-1:0] out_start_q;
  logic [RW-1:0] out_rem_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q   <= in_kind_i;
      bytes_q  <= in_data_i[BW-1:0];
      off_q    <= in_data_i[BW+OW-1:BW];
      status_q <= ffca_pkg::STAT_OK;
      start_q  <= '0;
    end else begin
      if (cmd_i.status_we) status_q <= cmd_i.status;
      if (cmd_i.start_we)  start_q  <= prod_q[OW-1:0];
    end
    if (cmd_i.need_we)   need_q  <= div_quo;
    if (cmd_i.first_we)  first_q <= div_quo;
    if (cmd_i.mul_start) prod_q  <= PW'(mul_a) * PW'(cb_eff);
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_start_q  <= start_q;
      out_rem_q    <= prod_q[RW-1:0];
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.kind      = kind_q;
    sts_o.div_done  = div_done;
    sts_o.need_zero = (need_q == '0);
    sts_o.need_gt_n = (need_q > QW'(n_eff));
    sts_o.outside   = (32'(off_q) >= 32'(prod_q));
    sts_o.found     = found_q;
    sts_o.rd_done   = !rd_pend_q && (rd_addr_q >= n_eff);
    sts_o.fill_last = (CW'(wr_idx_q) + CW'(1)) == fill_hi_q;
  end

  assign out_data_o = {1'b0, out_rem_q, out_start_q, out_status_q};

endmodule

// ----- hdl/ffca_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer for one request: divide, search or range check, bitmap update,
// free count sweep, result handoff.
// ----------------------------------------------------------------------------
module ffca_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ffca_pkg::sts_t sts_i,
  output ffca_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV_NEED,
    S_WAIT_NEED,
    S_ALLOC_CHK,
    S_SCAN,
    S_MARK,
    S_MUL_START,
    S_LATCH_START,
    S_DIV_OFF,
    S_WAIT_OFF,
    S_FREE_CHK,
    S_FILL,
    S_COUNT_INIT,
    S_COUNT,
    S_MUL_REM,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DIV_NEED;
        end
      end
      S_DIV_NEED: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAIT_NEED;
      end
      S_WAIT_NEED: begin
        if (sts_i.div_done) begin
          cmd_o.need_we = 1'b1;
          state_d = (sts_i.kind == ffca_pkg::KIND_FREE) ? S_DIV_OFF : S_ALLOC_CHK;
        end
      end
      S_ALLOC_CHK: begin
        if (sts_i.need_zero) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = ffca_pkg::STAT_ZERO;
          state_d         = S_COUNT_INIT;
        end else if (sts_i.need_gt_n) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = ffca_pkg::STAT_NORUN;
          state_d         = S_COUNT_INIT;
        end else begin
          cmd_o.rd_init = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_run = 1'b1;
        if (sts_i.found) begin
          cmd_o.fill_alloc_init = 1'b1;
          state_d               = S_MARK;
        end else if (sts_i.rd_done) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = ffca_pkg::STAT_NORUN;
          state_d         = S_COUNT_INIT;
        end
      end
      S_MARK: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) state_d = S_MUL_START;
      end
      S_MUL_START: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = ffca_pkg::MUL_START;
        state_d         = S_LATCH_START;
      end
      S_LATCH_START: begin
        cmd_o.start_we = 1'b1;
        cmd_o.rd_init  = 1'b1;
        state_d        = S_COUNT;
      end
      S_DIV_OFF: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_off   = 1'b1;
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = ffca_pkg::MUL_POOL;
        state_d         = S_WAIT_OFF;
      end
      S_WAIT_OFF: begin
        if (sts_i.div_done) begin
          cmd_o.first_we = 1'b1;
          state_d        = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        if (sts_i.outside) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = ffca_pkg::STAT_OUTSIDE;
          state_d         = S_COUNT_INIT;
        end else if (sts_i.need_zero) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status    = ffca_pkg::STAT_ZERO;
          state_d         = S_COUNT_INIT;
        end else begin
          cmd_o.fill_free_init = 1'b1;
          state_d              = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) state_d = S_COUNT_INIT;
      end
      S_COUNT_INIT: begin
        cmd_o.rd_init = 1'b1;
        state_d       = S_COUNT;
      end
      S_COUNT: begin
        cmd_o.rd_run     = 1'b1;
        cmd_o.count_mode = 1'b1;
        if (sts_i.rd_done) state_d = S_MUL_REM;
      end
      S_MUL_REM: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = ffca_pkg::MUL_CNT;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/ffca_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffca_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid_i,
  input logic                               s_axis_tready_o,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [ffca_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("request taken while busy");

  // a result valid never rises directly after a request is accepted
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(m_axis_tvalid_o))
    else $error("result one cycle after request");

  // an offset is returned only on success
  a_offset_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[19:2] != '0) |->
      m_axis_tdata_o[1:0] == ffca_pkg::STAT_OK)
    else $error("start offset on failed request");

endmodule

bind first_fit_chunk_allocator ffca_checker u_ffca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit chunk allocator.
// ----------------------------------------------------------------------------
// A scoreboard holds its own copy of the free bitmap and of both registers.
// Every accepted request word is run through it, and the result word it
// should produce is queued. Each result word taken from the block is compared
// field by field with the oldest queued one. A directed table runs first,
// with the plain cases typed in by hand. Then a series of pool settings
// follows, each with random traffic: mostly allocations and frees of live
// runs, with some junk mixed in. Back pressure and source gaps change from
// one setting to the next, and one setting opens with a long output stall
// so that the block backs up into its request port.
// ----------------------------------------------------------------------------
module testbench;
  import ffca_pkg::*;

  localparam int MAX_CHUNKS    = 64;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 400;
  localparam int ITEMS_PER_SET = 75;
  localparam int NUM_SETS      = 8;
  localparam int STALL_CYCLES  = 3000;

  typedef struct packed {
    status_e           status;
    logic [OFF_W-1:0]  start;
    logic [REM_W-1:0]  remaining;
  } result_t;

  typedef struct packed {
    logic              kind;
    logic [BYTES_W-1:0] nbytes;
    logic [OFF_W-1:0]  off;
    logic              typed;  // hand-typed result below, else scoreboard
    result_t           res;
  } row_t;

  typedef struct {
    logic [OFF_W-1:0]   off;
    logic [BYTES_W-1:0] nbytes;
  } span_t;

  // Directed words, pool of 64 chunks of 64 bytes straight out of reset.
  localparam row_t DIRECTED [18] = '{
    '{KIND_ALLOC, 19'd0,      18'd0,      1'b1, '{STAT_ZERO,    18'd0,   19'd4096}},
    '{KIND_ALLOC, 19'd1,      18'd0,      1'b1, '{STAT_OK,      18'd0,   19'd4032}},
    '{KIND_ALLOC, 19'd64,     18'd0,      1'b1, '{STAT_OK,      18'd64,  19'd3968}},
    '{KIND_ALLOC, 19'd65,     18'd0,      1'b1, '{STAT_OK,      18'd128, 19'd3840}},
    '{KIND_ALLOC, 19'd4097,   18'd0,      1'b1, '{STAT_NORUN,   18'd0,   19'd3840}},
    '{KIND_ALLOC, 19'h7FFFF,  18'h3FFFF,  1'b1, '{STAT_NORUN,   18'd0,   19'd3840}},
    '{KIND_FREE,  19'd64,     18'd4096,   1'b1, '{STAT_OUTSIDE, 18'd0,   19'd3840}},
    '{KIND_FREE,  19'd0,      18'h3FFFF,  1'b1, '{STAT_OUTSIDE, 18'd0,   19'd3840}},
    '{KIND_FREE,  19'd0,      18'd0,      1'b1, '{STAT_ZERO,    18'd0,   19'd3840}},
    // unaligned offset, then the same chunk freed twice
    '{KIND_FREE,  19'd64,     18'd70,     1'b0, '{STAT_OK,      18'd0,   19'd0}},
    '{KIND_FREE,  19'd1,      18'd127,    1'b0, '{STAT_OK,      18'd0,   19'd0}},
    '{KIND_ALLOC, 19'd64,     18'd0,      1'b0, '{STAT_OK,      18'd0,   19'd0}},
    // run that ends on the last chunk of the pool
    '{KIND_ALLOC, 19'd3840,   18'd0,      1'b1, '{STAT_OK,      18'd256, 19'd0}},
    '{KIND_ALLOC, 19'd1,      18'd0,      1'b1, '{STAT_NORUN,   18'd0,   19'd0}},
    // free past the pool end gets clipped
    '{KIND_FREE,  19'h7FFFF,  18'd4032,   1'b0, '{STAT_OK,      18'd0,   19'd0}},
    '{KIND_FREE,  19'd262144, 18'd0,      1'b1, '{STAT_OK,      18'd0,   19'd4096}},
    '{KIND_ALLOC, 19'd4096,   18'd0,      1'b1, '{STAT_OK,      18'd0,   19'd0}},
    '{KIND_FREE,  19'd4096,   18'd0,      1'b1, '{STAT_OK,      18'd0,   19'd4096}}
  };

  // Pool settings, raw register words: clamps, masking and a shrink with
  // chunks still held beyond the new end.
  localparam logic [CB_W-1:0] SET_CHUNK_BYTES [NUM_SETS] = '{
    13'd64, 13'd0, 13'd8191, 13'd4096, 13'd100, 13'd1, 13'd3, 13'd37
  };
  localparam logic [CB_W-1:0] SET_CHUNKS [NUM_SETS] = '{
    13'd64, 13'd0, 13'd127, 13'd64, 13'd20, 13'd64, 13'd1, 13'h1F05
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic                    cfg_index_i;
  logic [CB_W-1:0]         cfg_data_i;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  logic [IN_TDATA_W-1:0]   s_axis_tdata_i;   // [18:0] byte_count, [36:19] offset
  logic                    s_axis_tuser_i;   // [0] kind
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;   // [1:0] status, [19:2] start, [38:20] remaining

  // scoreboard state
  bit                  chunk_free_map [MAX_CHUNKS];
  logic [CB_W-1:0]     chunk_bytes_q;
  logic [NCFG_W-1:0]   pool_chunks_q;
  result_t             pending_results [$];
  span_t               live_spans [$];

  int  mismatches;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  stall_start;    // asks for the long back-pressure stretch
  bit  stall_active;   // high while that stretch runs
  int  cycle_count;

  first_fit_chunk_allocator #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Register values as the block applies them.
  function automatic int unsigned eff_chunk_bytes();
    int unsigned cb;
    cb = 32'(chunk_bytes_q);
    if (cb < 1) cb = 1;
    if (cb > 4096) cb = 4096;
    return cb;
  endfunction

  function automatic int unsigned eff_pool_chunks();
    int unsigned n;
    n = 32'(pool_chunks_q);
    if (n < 1) n = 1;
    if (n > MAX_CHUNKS) n = MAX_CHUNKS;
    return n;
  endfunction

  // Applies one request word to the bitmap and returns the result word.
  function automatic result_t allocator_step(input logic kind,
                                             input logic [BYTES_W-1:0] nbytes,
                                             input logic [OFF_W-1:0] off);
    int unsigned cb, n, need, s, i, first, stop, cnt, tmp;
    bit found;
    result_t r;
    span_t sp;
    cb = eff_chunk_bytes();
    n = eff_pool_chunks();
    need = (nbytes + cb - 1) / cb;
    r.status = STAT_OK;
    r.start = '0;
    if (kind == KIND_ALLOC) begin
      if (need == 0) begin
        r.status = STAT_ZERO;
      end else if (need > n) begin
        r.status = STAT_NORUN;
      end else begin
        // first fit: skip past the blocking chunk on every miss
        found = 1'b0;
        s = 0;
        while (s + need <= n) begin
          i = 0;
          while (i < need && chunk_free_map[s + i]) i++;
          if (i == need) begin
            found = 1'b1;
            break;
          end
          s = s + i + 1;
        end
        if (found) begin
          for (i = 0; i < need; i++) chunk_free_map[s + i] = 1'b0;
          tmp = s * cb;
          r.start = tmp[OFF_W-1:0];
          sp.off = r.start;
          sp.nbytes = nbytes;
          live_spans.push_back(sp);
        end else begin
          r.status = STAT_NORUN;
        end
      end
    end else begin
      if (off >= n * cb) begin
        r.status = STAT_OUTSIDE;
      end else if (need == 0) begin
        r.status = STAT_ZERO;
      end else begin
        first = off / cb;
        stop = first + need;
        if (stop > n) stop = n;
        for (i = first; i < stop; i++) chunk_free_map[i] = 1'b1;
      end
    end
    cnt = 0;
    for (i = 0; i < n; i++) if (chunk_free_map[i]) cnt++;
    tmp = cnt * cb;
    r.remaining = tmp[REM_W-1:0];
    return r;
  endfunction

  // Random request: mostly well-formed allocate/free traffic, some junk.
  task automatic pick_request(output logic kind, output logic [BYTES_W-1:0] nbytes,
                              output logic [OFF_W-1:0] off);
    int unsigned cb, n, roll, idx, need, tmp;
    span_t sp;
    cb = eff_chunk_bytes();
    n = eff_pool_chunks();
    roll = $urandom_range(0, 99);
    tmp = $urandom;
    off = tmp[OFF_W-1:0];     // don't care for allocate
    if (roll < 55) begin
      kind = KIND_ALLOC;
      case ($urandom_range(0, 9))
        0: nbytes = '0;
        1: begin
          tmp = $urandom;
          nbytes = tmp[BYTES_W-1:0];
        end
        default: begin
          need = $urandom_range(1, (n / 4 > 1) ? n / 4 : 1);
          tmp = need * cb - $urandom_range(0, cb - 1);
          nbytes = tmp[BYTES_W-1:0];
        end
      endcase
    end else if (roll < 90 && live_spans.size() > 0) begin
      // release a live run, sometimes by an address inside its first chunk
      kind = KIND_FREE;
      idx = $urandom_range(0, live_spans.size() - 1);
      sp = live_spans[idx];
      live_spans.delete(idx);
      tmp = 32'(sp.off);
      if ($urandom_range(0, 3) == 0) tmp = tmp + $urandom_range(0, cb - 1);
      off = tmp[OFF_W-1:0];
      nbytes = sp.nbytes;
    end else begin
      kind = 1'($urandom_range(0, 1));
      tmp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, n * cb + cb);
      off = tmp[OFF_W-1:0];
      tmp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4 * cb);
      nbytes = tmp[BYTES_W-1:0];
    end
  endtask

  // Offers one request word and holds it until taken. Valid is left high on
  // return; the next call or the phase end decides when it drops.
  task automatic send_request(input logic kind, input logic [BYTES_W-1:0] nbytes,
                              input logic [OFF_W-1:0] off, input logic typed,
                              input result_t typed_res);
    bit ready_seen;
    result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, off, nbytes};
    s_axis_tuser_i  <= kind;
    // ready is stable in the low half of the cycle; sample it there
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    want = allocator_step(kind, nbytes, off);
    if (typed) want = typed_res;
    pending_results.push_back(want);
  endtask

  task automatic write_reg(input logic index, input logic [CB_W-1:0] value);
    bit ready_seen;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      ready_seen = cfg_ready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    if (index == REG_CHUNK_BYTES) chunk_bytes_q = value;
    else pool_chunks_q = value[NCFG_W-1:0];
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Long output stall, counted here once requested.
  initial begin : long_stall
    stall_active = 1'b0;
    wait (stall_start);
    stall_active = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    stall_active = 1'b0;
  end

  // Result sink: random back pressure plus the long stall.
  initial begin : result_sink
    bit taken;
    logic [OUT_TDATA_W-1:0] word;
    result_t want;
    mismatches      = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      taken = m_axis_tvalid_o && m_axis_tready_i;
      word  = m_axis_tdata_o;
      @(posedge clk_i);
      if (taken) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual %h", $time, word);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (word[1:0] !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, word[1:0]);
            mismatches++;
          end
          if (word[19:2] !== want.start) begin
            $display("%0t: start_offset expected %0d actual %0d",
                     $time, want.start, word[19:2]);
            mismatches++;
          end
          if (word[38:20] !== want.remaining) begin
            $display("%0t: remaining_bytes expected %0d actual %0d",
                     $time, want.remaining, word[38:20]);
            mismatches++;
          end
        end
      end
      if (stall_active) begin
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic kind;
    logic [BYTES_W-1:0] nbytes;
    logic [OFF_W-1:0] off;
    result_t none;
    // all inputs known from time zero
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_CHUNK_BYTES;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = KIND_ALLOC;
    stall_start     = 1'b0;
    send_idle_pct   = 13;
    recv_stall_pct  = 13;
    none            = '0;
    foreach (chunk_free_map[i]) chunk_free_map[i] = 1'b1;
    chunk_bytes_q   = CB_RESET;
    pool_chunks_q   = NCFG_RESET;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; ready holds off through the post-reset bitmap sweep
    foreach (DIRECTED[r])
      send_request(DIRECTED[r].kind, DIRECTED[r].nbytes, DIRECTED[r].off,
                   DIRECTED[r].typed, DIRECTED[r].res);
    wait_drained();

    for (int p = 0; p < NUM_SETS; p++) begin
      write_reg(REG_CHUNK_BYTES, SET_CHUNK_BYTES[p]);
      write_reg(REG_CHUNKS, SET_CHUNKS[p]);
      cfg_valid_i <= 1'b0;
      live_spans.delete();   // old spans mean other chunks under a new size
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
        end
      endcase
      // long sink stall with a busy source: block must back up
      if (p == 4) stall_start = 1'b1;
      repeat (ITEMS_PER_SET) begin
        pick_request(kind, nbytes, off);
        send_request(kind, nbytes, off, 1'b0, none);
      end
      wait_drained();
    end

    // catch stray words after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
